@@ hdl/ibrl_pkg.sv @@
// ----------------------------------------------------------------------------
// ibrl_pkg
// Shared types and constants of the IPv6 binary range lookup core.
// ----------------------------------------------------------------------------
package ibrl_pkg;

  localparam int ADDR_W      = 128;
  localparam int HALF_W      = 64;
  localparam int SLOT_W      = 10;
  localparam int CNT_W       = 11;
  localparam int PLEN_W      = 8;
  localparam int TABLE_DEPTH = 1024;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

  localparam logic [CNT_W-1:0]  TABLE_DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [PLEN_W-1:0] PLEN_MAX      = 8'd128;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } ibrl_op_e;

  // Input word as seen on the port
  typedef struct packed {
    ibrl_op_e             opcode;
    logic [SLOT_W-1:0]    slot_index;
    logic [HALF_W-1:0]    address_hi;
    logic [HALF_W-1:0]    address_lo;
    logic [PLEN_W-1:0]    prefix_length;
  } ibrl_in_t;

  // Result word
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] match_slot;
  } ibrl_out_t;

  // Classified command between front and back; key is the lower bound
  // for a load and the search address for a lookup
  typedef struct packed {
    ibrl_op_e          op;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] key;
    logic [ADDR_W-1:0] upper;
  } ibrl_cmd_t;

  // Queue status toward front and back
  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [FIFO_CNT_W-1:0] count;
  } ibrl_q_status_t;

endpackage

@@ hdl/ipv6_binary_range_lookup_core.sv @@
// A load is written into the table when the search engine takes it from the queue.
// A lookup makes p probes, with p at most ceil(log2(n+1)) for n entries.
// Each probe is one registered table read plus one 128-bit range compare.
// Lookups run one at a time, while a four-word queue accepts words.
// Reset clears entry_count, the queue and the sequencer; the table is not cleared.
// ----------------------------------------------------------------------------
// ipv6_binary_range_lookup_core
// IPv6 prefix range table with binary range search over sorted slots.
// ----------------------------------------------------------------------------
module ipv6_binary_range_lookup_core import ibrl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  ibrl_in_t         in_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output ibrl_out_t        out_o,
  input  logic             out_stall_i
);

  logic [CNT_W-1:0] entry_count_q;
  ibrl_q_status_t   q_status;
  ibrl_cmd_t        push_cmd;
  ibrl_cmd_t        head_cmd;
  logic             push;
  logic             pop;

  // Hold the entry_count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  ibrl_front u_front (
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .in_stall_o (in_stall_o),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  ibrl_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .status_o   (q_status)
  );

  ibrl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_count_i (entry_count_q),
    .q_status_i    (q_status),
    .q_cmd_i       (head_cmd),
    .q_pop_o       (pop),
    .out_valid_o   (out_valid_o),
    .out_o         (out_o),
    .out_stall_i   (out_stall_i)
  );

  // A miss reports slot zero
  a_miss_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.hit |-> out_o.match_slot == '0)
    else $error("miss with nonzero match_slot");

  // Queue never holds more than its depth
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("command queue count out of range");

  // The engine pops only a nonempty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_status.count != '0)
    else $error("pop from empty command queue");

endmodule

@@ hdl/ibrl_front.sv @@
// ----------------------------------------------------------------------------
// ibrl_front
// Accepts input words, classifies them and turns loads into range bounds.
// ----------------------------------------------------------------------------
module ibrl_front import ibrl_pkg::*; (
  input  logic           in_valid_i,
  input  ibrl_in_t       in_i,
  output logic           in_stall_o,
  input  ibrl_q_status_t q_status_i,
  output logic           push_o,
  output ibrl_cmd_t      cmd_o
);

  logic [PLEN_W-1:0] plen;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] lower;

  // Saturate the prefix length and build the prefix mask
  always_comb begin
    plen  = (in_i.prefix_length > PLEN_MAX) ? PLEN_MAX : in_i.prefix_length;
    addr  = {in_i.address_hi, in_i.address_lo};
    mask  = ~({ADDR_W{1'b1}} >> plen);
    base  = addr & mask;
    lower = (base == '0) ? '0 : base - ADDR_W'(1);
  end

  // Classify: loads carry bounds, lookups carry the address
  always_comb begin
    cmd_o.op   = in_i.opcode;
    cmd_o.slot = in_i.slot_index;
    unique case (in_i.opcode)
      OP_LOAD: begin
        cmd_o.key   = lower;
        cmd_o.upper = base | ~mask;
      end
      OP_LOOKUP: begin
        cmd_o.key   = addr;
        cmd_o.upper = '0;
      end
      default: begin
        cmd_o.key   = addr;
        cmd_o.upper = '0;
      end
    endcase
  end

  // Hold the input while the queue is full
  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

endmodule

@@ hdl/ibrl_fifo.sv @@
// ----------------------------------------------------------------------------
// ibrl_fifo
// Short command queue that decouples the front from the search engine.
// ----------------------------------------------------------------------------
module ibrl_fifo import ibrl_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ibrl_cmd_t      push_cmd_i,
  input  logic           pop_i,
  output ibrl_cmd_t      head_o,
  output ibrl_q_status_t status_o
);

  ibrl_cmd_t             entries_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + FIFO_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + FIFO_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign head_o          = entries_q[rd_ptr_q];
  assign status_o.full   = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign status_o.empty  = (count_q == '0);
  assign status_o.count  = count_q;

endmodule

@@ hdl/ibrl_back.sv @@
// ----------------------------------------------------------------------------
// ibrl_back
// Range table memory and binary search engine; each probe is a READ then a CMP state.
// ----------------------------------------------------------------------------
module ibrl_back import ibrl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] entry_count_i,
  input  ibrl_q_status_t   q_status_i,
  input  ibrl_cmd_t        q_cmd_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  output ibrl_out_t        out_o,
  input  logic             out_stall_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] lower;
    logic [ADDR_W-1:0] upper;
  } range_t;

  range_t            table_mem [TABLE_DEPTH];
  range_t            rd_data_q;

  state_e            state_q;
  logic [ADDR_W-1:0] addr_q;
  logic [CNT_W-1:0]  lo_q;
  logic [CNT_W-1:0]  hi_q;
  logic [SLOT_W-1:0] mid_q;
  logic              hit_q;
  logic [SLOT_W-1:0] slot_q;
  logic              out_valid_q;
  ibrl_out_t         out_q;

  logic              take;
  logic              wr_en;
  logic              rd_en;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W:0]    mid_sum;
  logic [SLOT_W-1:0] mid_c;
  logic              in_range;
  logic              go_left;
  logic [CNT_W-1:0]  lo_n;
  logic [CNT_W-1:0]  hi_n;
  logic              out_free;

  // Decode queue head and probe position
  always_comb begin
    take     = (state_q == S_IDLE) && !q_status_i.empty;
    wr_en    = take && (q_cmd_i.op == OP_LOAD);
    rd_en    = (state_q == S_READ);
    n_eff    = (entry_count_i > TABLE_DEPTH_C) ? TABLE_DEPTH_C : entry_count_i;
    mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} - (CNT_W+1)'(1);
    mid_c    = mid_sum[SLOT_W:1];
    out_free = !out_valid_q || !out_stall_i;
  end

  assign q_pop_o = take;

  // Compare the probed range and narrow the window
  always_comb begin
    in_range = (rd_data_q.lower < addr_q) && (addr_q <= rd_data_q.upper);
    go_left  = (addr_q <= rd_data_q.lower);
    lo_n     = lo_q;
    hi_n     = hi_q;
    priority if (in_range) begin
      lo_n = {1'b0, mid_q} + CNT_W'(1);
    end else if (go_left) begin
      hi_n = {1'b0, mid_q};
    end else begin
      lo_n = {1'b0, mid_q} + CNT_W'(1);
    end
  end

  // Table memory: write on load, registered read on probe
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[q_cmd_i.slot] <= '{lower: q_cmd_i.key, upper: q_cmd_i.upper};
    end
    if (rd_en) begin
      rd_data_q <= table_mem[mid_c];
    end
  end

  // Search sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      addr_q      <= '0;
      hit_q       <= 1'b0;
      slot_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
    end else begin
      // Raise valid on a finished search, drop it once the word is taken
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (take && (q_cmd_i.op == OP_LOOKUP)) begin
            addr_q  <= q_cmd_i.key;
            lo_q    <= '0;
            hi_q    <= n_eff;
            hit_q   <= 1'b0;
            slot_q  <= '0;
            state_q <= (n_eff != '0) ? S_READ : S_DONE;
          end
        end
        S_READ: begin
          mid_q   <= mid_c;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (in_range) begin
            hit_q  <= 1'b1;
            slot_q <= mid_q;
          end
          lo_q    <= lo_n;
          hi_q    <= hi_n;
          state_q <= (lo_n < hi_n) ? S_READ : S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_q.hit        <= hit_q;
            out_q.match_slot <= hit_q ? slot_q : '0;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ tb/ipv6_binary_range_lookup_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv6_binary_range_lookup_core_tb
// Drives prefix loads and address lookups into the range lookup core. It
// rebuilds every table range and runs the binary search in the bench, then
// checks each result word field by field. The bench changes entry_count
// between phases, adds random gaps and stalls on both sides, and holds off
// the output for one long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module ipv6_binary_range_lookup_core_tb;
  import ibrl_pkg::*;

  localparam int LOAD_SETTLE     = 16;
  localparam int TAIL_CYCLES     = 32;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_PRINTED     = 30;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  logic             in_valid;
  ibrl_in_t         in_word;
  logic             in_stall;
  logic             out_valid;
  ibrl_out_t        out_word;
  logic             out_stall = 1'b0;

  // Bench copy of the table: exclusive lower bound and inclusive upper bound
  logic [ADDR_W-1:0] range_lo [TABLE_DEPTH];
  logic [ADDR_W-1:0] range_hi [TABLE_DEPTH];
  logic [CNT_W-1:0]  entry_count_shadow;
  ibrl_out_t         lookup_answers_q [$];
  ibrl_out_t         due_answer;

  int mismatch_count;
  int burst_left;
  bit tx_gaps_on;

  // Receiver stall control
  logic [7:0] hold_req;
  logic [7:0] hold_seen   = '0;
  int         hold_left   = 0;
  int         rx_run_left = 0;
  bit         rx_stalling = 1'b0;
  logic       rx_stalls_on;

  ipv6_binary_range_lookup_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_i        (in_word),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_o       (out_word),
    .out_stall_i (out_stall)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("%0t MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
    end
  endtask

  function automatic logic [ADDR_W-1:0] rand128();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  function automatic int searched_slots();
    return (entry_count_shadow > TABLE_DEPTH_C) ? TABLE_DEPTH : int'(entry_count_shadow);
  endfunction

  // Turn a load word into its stored range
  task automatic store_prefix(input ibrl_in_t word);
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] base;
    int unsigned       len;
    addr = {word.address_hi, word.address_lo};
    len  = (word.prefix_length > PLEN_MAX) ? 128 : word.prefix_length;
    mask = ~({ADDR_W{1'b1}} >> len);
    base = addr & mask;
    range_lo[word.slot_index] = (base == '0) ? '0 : base - 1'b1;
    range_hi[word.slot_index] = base | ~mask;
  endtask

  // Binary search; keep the last probe whose range holds the address
  function automatic ibrl_out_t search_ranges(input logic [ADDR_W-1:0] addr);
    ibrl_out_t answer;
    int        left;
    int        right;
    int        mid;
    answer = '0;
    left   = 0;
    right  = searched_slots() - 1;
    while (left <= right) begin
      mid = (left + right) / 2;
      if (range_lo[mid] < addr && addr <= range_hi[mid]) begin
        answer.hit        = 1'b1;
        answer.match_slot = SLOT_W'(mid);
        left              = mid + 1;
      end else if (addr <= range_lo[mid]) begin
        right = mid - 1;
      end else begin
        left = mid + 1;
      end
    end
    return answer;
  endfunction

  function automatic ibrl_in_t make_load(input int slot, input logic [ADDR_W-1:0] addr,
                                         input logic [PLEN_W-1:0] plen);
    ibrl_in_t word;
    word.opcode        = OP_LOAD;
    word.slot_index    = SLOT_W'(slot);
    word.address_hi    = addr[ADDR_W-1:HALF_W];
    word.address_lo    = addr[HALF_W-1:0];
    word.prefix_length = plen;
    return word;
  endfunction

  // Ignored fields carry random bits
  function automatic ibrl_in_t make_lookup(input logic [ADDR_W-1:0] addr);
    ibrl_in_t word;
    word.opcode        = OP_LOOKUP;
    word.slot_index    = SLOT_W'($urandom());
    word.address_hi    = addr[ADDR_W-1:HALF_W];
    word.address_lo    = addr[HALF_W-1:0];
    word.prefix_length = PLEN_W'($urandom());
    return word;
  endfunction

  function automatic logic [PLEN_W-1:0] pick_plen();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 70) return PLEN_W'($urandom_range(10, 128));
    if (kind < 80) return PLEN_W'($urandom_range(129, 255));
    if (kind < 88) return PLEN_W'($urandom_range(0, 9));
    if (kind < 94) return PLEN_MAX;
    return 8'd64;
  endfunction

  // Top address bits carry the slot number, so ranges ascend with the slot when the prefix length is at least SLOT_W
  function automatic logic [ADDR_W-1:0] ordered_prefix(input int slot);
    logic [ADDR_W-1:0] addr;
    addr = rand128();
    addr[ADDR_W-1 -: SLOT_W] = SLOT_W'(slot);
    return addr;
  endfunction

  // Address inside, on the edge of, or outside a searched range
  function automatic logic [ADDR_W-1:0] pick_probe_addr(input int n);
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] r;
    int                slot;
    int                kind;
    r = rand128();
    if (n == 0) return r;
    slot = $urandom_range(0, n - 1);
    lo   = range_lo[slot];
    hi   = range_hi[slot];
    span = hi - lo;
    kind = $urandom_range(0, 99);
    if (kind < 65) return (span == '0) ? hi : lo + 1'b1 + (r % span);
    if (kind < 75) return lo;
    if (kind < 85) return hi;
    if (kind < 92) return hi + 1'b1;
    return r;
  endfunction

  // Send one word, with gaps between bursts; predict at acceptance
  task automatic send_word(input ibrl_in_t word);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = tx_gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_word  <= word;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (word.opcode == OP_LOAD) begin
      store_prefix(word);
    end else begin
      lookup_answers_q.push_back(search_ranges({word.address_hi, word.address_lo}));
    end
  endtask

  // Hold the input until every answer is in, then let trailing loads finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (lookup_answers_q.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  task automatic write_entry_count(input logic [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we             <= 1'b0;
    entry_count_shadow = value;
  endtask

  // Receiver: long hold-off on request, otherwise random stall runs
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!rx_stalls_on) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_run_left == 0) begin
        rx_stalling = !rx_stalling;
        rx_run_left = rx_stalling ? $urandom_range(1, 6) : $urandom_range(1, 10);
      end
      rx_run_left--;
      out_stall <= rx_stalling;
    end
  end

  // Compare each result word with the oldest answer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (lookup_answers_q.size() == 0) begin
        report_mismatch("result word with no lookup pending", out_word.match_slot, 0);
      end else begin
        due_answer = lookup_answers_q.pop_front();
        if (out_word.hit !== due_answer.hit) begin
          report_mismatch("hit", out_word.hit, due_answer.hit);
        end
        if (out_word.match_slot !== due_answer.match_slot) begin
          report_mismatch("match_slot", out_word.match_slot, due_answer.match_slot);
        end
      end
    end
  end

  // Lookups into the table left empty by reset
  task automatic test_empty_table();
    send_word(make_lookup('0));
    send_word(make_lookup({ADDR_W{1'b1}}));
    wait_idle();
  endtask

  // Hand-built four slot table: zero base, saturated length, edges of ranges
  task automatic test_directed_ranges();
    logic [ADDR_W-1:0] host;
    host = 128'h2001_0db8_0000_0000_0000_0000_0000_0001;
    write_entry_count(CNT_W'(4));
    send_word(make_load(0, '0, 8'hFF));
    send_word(make_load(1, {64'h1, 64'(rand128())}, 8'd64));
    send_word(make_load(2, host, PLEN_MAX));
    send_word(make_load(3, {ADDR_W{1'b1}}, 8'd8));
    send_word(make_load(TABLE_DEPTH - 1, rand128(), 8'd48));
    send_word(make_lookup('0));
    send_word(make_lookup(128'd1));
    send_word(make_lookup({64'h1, 64'h0}));
    send_word(make_lookup({64'h1, {HALF_W{1'b1}}}));
    send_word(make_lookup({64'h2, 64'h0}));
    send_word(make_lookup(host));
    send_word(make_lookup(host - 1'b1));
    send_word(make_lookup({ADDR_W{1'b1}}));
    send_word(make_lookup({8'hFF, 120'h0}));
    // zero length prefix: range covers every nonzero address
    send_word(make_load(0, rand128(), 8'd0));
    send_word(make_lookup({64'h5, 64'h5}));
    send_word(make_lookup('0));
    wait_idle();
    write_entry_count(CNT_W'(1));
    send_word(make_lookup(128'd7));
    send_word(make_lookup('0));
    wait_idle();
  endtask

  // Fill the searched slots, then mix lookups with table rewrites
  task automatic test_random_tables();
    int  n;
    int  pick;
    bit  ordered;
    for (int phase = 0; phase < 12; phase++) begin
      wait_idle();
      n            = (phase < 4) ? phase : $urandom_range(4, 48);
      ordered      = (phase % 5) != 4;
      tx_gaps_on   = (phase % 4) != 3;
      rx_stalls_on <= (phase % 4) != 3;
      write_entry_count(CNT_W'(n));
      for (int slot = 0; slot < n; slot++) begin
        send_word(make_load(slot, ordered ? ordered_prefix(slot) : rand128(), pick_plen()));
      end
      for (int k = 0; k < 20; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_word(make_lookup(pick_probe_addr(n)));
        end else if (pick < 78) begin
          send_word(make_lookup(rand128()));
        end else if (pick < 90 && n > 0) begin
          pick = $urandom_range(0, n - 1);
          send_word(make_load(pick, ordered_prefix(pick), pick_plen()));
        end else begin
          send_word(make_load($urandom_range(0, TABLE_DEPTH - 1), rand128(), pick_plen()));
        end
      end
    end
    wait_idle();
  endtask

  // Whole table, then counts at and above the table depth
  task automatic test_full_table();
    tx_gaps_on   = 1'b1;
    rx_stalls_on <= 1'b1;
    write_entry_count(TABLE_DEPTH_C);
    for (int slot = 0; slot < TABLE_DEPTH; slot++) begin
      send_word(make_load(slot, ordered_prefix(slot), pick_plen()));
    end
    repeat (60) send_word(make_lookup(pick_probe_addr(TABLE_DEPTH)));
    wait_idle();
    write_entry_count({CNT_W{1'b1}});
    repeat (30) send_word(make_lookup(pick_probe_addr(TABLE_DEPTH)));
    wait_idle();
    write_entry_count(CNT_W'(1500));
    repeat (10) send_word(make_lookup(pick_probe_addr(TABLE_DEPTH)));
    wait_idle();
  endtask

  // Long output hold-off while the sender keeps offering lookups
  task automatic test_output_hold_off();
    tx_gaps_on = 1'b0;
    hold_req   <= hold_req + 1'b1;
    repeat (16) send_word(make_lookup(pick_probe_addr(searched_slots())));
    wait_idle();
  endtask

  initial begin
    int waited;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_valid           = 1'b0;
    in_word            = '0;
    hold_req           = '0;
    rx_stalls_on       = 1'b1;
    tx_gaps_on         = 1'b1;
    burst_left         = 0;
    mismatch_count     = 0;
    entry_count_shadow = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_directed_ranges();
    test_random_tables();
    test_full_table();
    test_output_hold_off();

    // Drain, then give late words a chance to show up
    in_valid <= 1'b0;
    waited   = 0;
    while (lookup_answers_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (lookup_answers_q.size() != 0) begin
      report_mismatch("lookup answers never delivered", lookup_answers_q.size(), 0);
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ ipv6_binary_range_lookup_core.f @@
hdl/ibrl_pkg.sv
hdl/ibrl_front.sv
hdl/ibrl_fifo.sv
hdl/ibrl_back.sv
hdl/ipv6_binary_range_lookup_core.sv
tb/ipv6_binary_range_lookup_core_tb.sv
